FILE: hdl/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

	// Width of one multiplier digit; each cell of the product chain consumes one digit.
	localparam int DIGIT_W = 16;

	// Configuration register format.
	localparam int          CFG_W        = 16;
	localparam logic [15:0] MAX_ITER_RST = 16'd255;

endpackage

`default_nettype wire

FILE: hdl/mbe_cell.sv
`default_nettype none

// One digit slice of the squaring chain. It multiplies the full operand
// magnitudes by its own digit of the multiplier operand and adds the shifted
// partial products into the running sums for x*x, y*y and x*y.
module mbe_cell #(
	parameter int NUM_DIGITS = 2,
	parameter int CELL_INDEX = 0
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         in_valid,
	input  wire logic [NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]       in_ax,
	input  wire logic [NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]       in_ay,
	input  wire logic [2*NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]     in_pxx,
	input  wire logic [2*NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]     in_pyy,
	input  wire logic [2*NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]     in_pxy,
	output logic                                              out_valid,
	output logic [NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]            out_ax,
	output logic [NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]            out_ay,
	output logic [2*NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]          out_pxx,
	output logic [2*NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]          out_pyy,
	output logic [2*NUM_DIGITS*mbe_pkg::DIGIT_W-1:0]          out_pxy
);

	localparam int DW  = mbe_pkg::DIGIT_W;
	localparam int OW  = NUM_DIGITS * DW;
	localparam int MW  = OW + DW;
	localparam int SW  = 2 * OW;
	localparam int SH  = CELL_INDEX * DW;

	logic [DW-1:0] dig_x;
	logic [DW-1:0] dig_y;
	logic [MW-1:0] m_xx;
	logic [MW-1:0] m_yy;
	logic [MW-1:0] m_xy;
	logic [SW-1:0] t_xx;
	logic [SW-1:0] t_yy;
	logic [SW-1:0] t_xy;

	logic          valid_q;
	logic [OW-1:0] ax_q;
	logic [OW-1:0] ay_q;
	logic [SW-1:0] pxx_q;
	logic [SW-1:0] pyy_q;
	logic [SW-1:0] pxy_q;

	assign dig_x = in_ax[SH +: DW];
	assign dig_y = in_ay[SH +: DW];

	assign m_xx = MW'(in_ax) * MW'(dig_x);
	assign m_yy = MW'(in_ay) * MW'(dig_y);
	assign m_xy = MW'(in_ax) * MW'(dig_y);

	assign t_xx = SW'(m_xx) << SH;
	assign t_yy = SW'(m_yy) << SH;
	assign t_xy = SW'(m_xy) << SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// Advance the partial sums one slice every cycle.
	always_ff @(posedge clk) begin
		ax_q  <= in_ax;
		ay_q  <= in_ay;
		pxx_q <= in_pxx + t_xx;
		pyy_q <= in_pyy + t_yy;
		pxy_q <= in_pxy + t_xy;
	end

	assign out_valid = valid_q;
	assign out_ax    = ax_q;
	assign out_ay    = ay_q;
	assign out_pxx   = pxx_q;
	assign out_pyy   = pyy_q;
	assign out_pxy   = pxy_q;

endmodule

`default_nettype wire

FILE: hdl/mandelbrot_escape_time.sv
`default_nettype none

// Escape-time iteration for one point c = c_real + i*c_imag (signed fixed
// point, FRAC_BITS fractional bits). z starts at c and z = z*z + c repeats
// until |z|^2 > 4.0 or the count reaches max_iterations.
//
// Input: drive c_real/c_imag and raise start; the word is taken at a clock
// edge where start is high and busy is low. busy stays high while the point
// iterates and drops in the cycle the result appears.
// Output: done is high for exactly one cycle with iteration_count, z_real and
// z_imag valid in that cycle. The receiver cannot stall; capture it then.
// Config: cfg_we/cfg_wdata write max_iterations (reset 255); write only while
// idle. The limit is sampled when a point is taken and clamped to the count
// width.
//
// Iteration: each pass runs the operand magnitudes through a chain of
// NC = ceil(DATA_WIDTH/16) product cells between a check state and an update
// state; the sequencer waits in ST_WAIT until the chain delivers. done is
// registered from the check state when the limit stops the point, from the
// update state when the point escapes. One point is in flight at a time;
// the next may be taken in the cycle done is high.
// Reset clears the control state, the pending strobe and restores the limit.
module mandelbrot_escape_time #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 28,
	parameter int ITER_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic signed [DATA_WIDTH-1:0]   c_real,
	input  wire logic signed [DATA_WIDTH-1:0]   c_imag,
	input  wire logic                           cfg_we,
	input  wire logic [mbe_pkg::CFG_W-1:0]      cfg_wdata,
	output logic                                done,
	output logic [ITER_WIDTH-1:0]               iteration_count,
	output logic signed [DATA_WIDTH-1:0]        z_real,
	output logic signed [DATA_WIDTH-1:0]        z_imag
);

	localparam int DIG  = mbe_pkg::DIGIT_W;
	localparam int NC   = (DATA_WIDTH + DIG - 1) / DIG;
	localparam int OW   = NC * DIG;
	localparam int SW   = 2 * OW;
	localparam int PW_A = 2 * DATA_WIDTH + 2;
	localparam int PW_B = DATA_WIDTH + FRAC_BITS;
	localparam int PW_C = 2 * FRAC_BITS + 3;
	localparam int PW_AB = (PW_A > PW_B) ? PW_A : PW_B;
	localparam int PW   = (PW_AB > PW_C) ? PW_AB : PW_C;
	localparam int CW   = mbe_pkg::CFG_W;
	localparam int LW   = (CW > ITER_WIDTH) ? CW : ITER_WIDTH;

	localparam logic [PW-1:0] FOUR   = {{(PW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);
	localparam logic [LW-1:0] CAP_EXT = LW'({ITER_WIDTH{1'b1}});

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_UPD   = 2'd3;

	logic [1:0]            state_q;
	logic [CW-1:0]         max_iter_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;
	logic [DATA_WIDTH-1:0] cx_q;
	logic [DATA_WIDTH-1:0] cy_q;
	logic [ITER_WIDTH-1:0] n_q;
	logic [ITER_WIDTH-1:0] limit_q;
	logic                  gt_q;
	logic [DATA_WIDTH-1:0] re_q;
	logic [DATA_WIDTH-1:0] im_q;

	logic                  done_q;
	logic [ITER_WIDTH-1:0] count_q;
	logic [DATA_WIDTH-1:0] zr_q;
	logic [DATA_WIDTH-1:0] zi_q;

	logic                  accept;
	logic                  launch;
	logic                  emit;
	logic [LW-1:0]         max_ext;
	logic [ITER_WIDTH-1:0] limit_d;
	logic [DATA_WIDTH-1:0] mag_x;
	logic [DATA_WIDTH-1:0] mag_y;

	// Product chain taps.
	logic          v_c   [0:NC];
	logic [OW-1:0] ax_c  [0:NC];
	logic [OW-1:0] ay_c  [0:NC];
	logic [SW-1:0] pxx_c [0:NC];
	logic [SW-1:0] pyy_c [0:NC];
	logic [SW-1:0] pxy_c [0:NC];

	logic [PW-1:0] xx_w;
	logic [PW-1:0] yy_w;
	logic [PW-1:0] xy_w;
	logic [PW-1:0] sq_w;
	logic [PW-1:0] re_full;
	logic [PW-1:0] xy_sgn;
	logic [PW-1:0] im_full;
	logic          sign_xy;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign launch = (state_q == ST_CHECK) && (n_q != limit_q);
	assign emit   = ((state_q == ST_CHECK) && (n_q == limit_q)) ||
	                ((state_q == ST_UPD) && gt_q);

	// Clamp the configured limit to what the counter can hold.
	assign max_ext = LW'(max_iter_q);
	assign limit_d = (max_ext > CAP_EXT) ? CAP_EXT[ITER_WIDTH-1:0] : max_ext[ITER_WIDTH-1:0];

	// Operand magnitudes; the most negative value maps to its unsigned size.
	assign mag_x = x_q[DATA_WIDTH-1] ? DATA_WIDTH'(~x_q + 1'b1) : x_q;
	assign mag_y = y_q[DATA_WIDTH-1] ? DATA_WIDTH'(~y_q + 1'b1) : y_q;

	assign v_c[0]   = launch;
	assign ax_c[0]  = OW'(mag_x);
	assign ay_c[0]  = OW'(mag_y);
	assign pxx_c[0] = '0;
	assign pyy_c[0] = '0;
	assign pxy_c[0] = '0;

	for (genvar gi = 0; gi < NC; gi++) begin : g_cell
		mbe_cell #(
			.NUM_DIGITS (NC),
			.CELL_INDEX (gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[gi]),
			.in_ax     (ax_c[gi]),
			.in_ay     (ay_c[gi]),
			.in_pxx    (pxx_c[gi]),
			.in_pyy    (pyy_c[gi]),
			.in_pxy    (pxy_c[gi]),
			.out_valid (v_c[gi+1]),
			.out_ax    (ax_c[gi+1]),
			.out_ay    (ay_c[gi+1]),
			.out_pxx   (pxx_c[gi+1]),
			.out_pyy   (pyy_c[gi+1]),
			.out_pxy   (pxy_c[gi+1])
		);
	end

	// Full-precision products: squares are nonnegative, x*y takes its sign
	// from the operands. Floor by dropping the fraction bits of the two's
	// complement value.
	assign xx_w    = PW'(pxx_c[NC]);
	assign yy_w    = PW'(pyy_c[NC]);
	assign xy_w    = PW'(pxy_c[NC]);
	assign sign_xy = x_q[DATA_WIDTH-1] ^ y_q[DATA_WIDTH-1];
	assign sq_w    = xx_w + yy_w;
	assign re_full = xx_w - yy_w;
	assign xy_sgn  = sign_xy ? (PW'(0) - xy_w) : xy_w;
	assign im_full = xy_sgn << 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_iter_q <= mbe_pkg::MAX_ITER_RST;
			done_q     <= 1'b0;
		end else begin
			done_q <= emit;
			if (cfg_we) begin
				max_iter_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= launch ? ST_WAIT : ST_IDLE;
				end
				ST_WAIT: begin
					if (v_c[NC]) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= gt_q ? ST_IDLE : ST_CHECK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Iteration datapath: load the point, capture products, then update z.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= c_real;
			y_q     <= c_imag;
			cx_q    <= c_real;
			cy_q    <= c_imag;
			n_q     <= '0;
			limit_q <= limit_d;
		end else if ((state_q == ST_UPD) && !gt_q) begin
			x_q <= re_q + cx_q;
			y_q <= im_q + cy_q;
			n_q <= n_q + 1'b1;
		end
		if ((state_q == ST_WAIT) && v_c[NC]) begin
			gt_q <= (sq_w > FOUR);
			re_q <= re_full[FRAC_BITS +: DATA_WIDTH];
			im_q <= im_full[FRAC_BITS +: DATA_WIDTH];
		end
		if (emit) begin
			count_q <= n_q;
			zr_q    <= x_q;
			zi_q    <= y_q;
		end
	end

	assign done            = done_q;
	assign iteration_count = count_q;
	assign z_real          = zr_q;
	assign z_imag          = zi_q;

`ifndef SYNTHESIS
	// A result word only follows a cycle spent working on a point.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a point in flight");

	// The reported count never passes the limit sampled for the point.
	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (iteration_count <= limit_q))
		else $error("iteration count beyond limit");

	// Products leave the chain only while the sequencer waits for them.
	a_chain_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		v_c[NC] |-> (state_q == ST_WAIT))
		else $error("product chain output outside wait state");

	// An accepted point keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted point did not raise busy");
`endif

endmodule

`default_nettype wire
